### src/iorb_pkg.sv
// Shared types, constants and helpers for the I/O register block with BCD clock.
package iorb_pkg;

  localparam int CLOCK_RAM_BYTES     = 32;
  localparam int RTC_IDX_W           = $clog2(CLOCK_RAM_BYTES);
  localparam int TICKS_PER_HUNDREDTH = 10;

  localparam int CMD_W    = 2;
  localparam int OFFSET_W = 14;
  localparam int DATA_W   = 32;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [DATA_W-1:0]   word_t;
  typedef logic [7:0]          byte_t;

  localparam cmd_t CMD_READ  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_TICK  = 2'd2;

  // Word offsets of the decoded registers
  localparam offset_t OFS_ID_A500   = 14'h017;
  localparam offset_t OFS_PAR_PTR   = 14'h02b;
  localparam offset_t OFS_ID_1F     = 14'h030;
  localparam offset_t OFS_MISC      = 14'h06c;
  localparam offset_t OFS_LIO_MASKA = 14'h071;
  localparam offset_t OFS_LIO_MASKB = 14'h073;
  localparam offset_t OFS_INT_MASKA = 14'h075;
  localparam offset_t OFS_INT_MASKB = 14'h076;

  // Upper offset bits of the 16-word ID window and the clock RAM window
  localparam logic [OFFSET_W-5:0]         ID_WIN_HI  = 10'h034;
  localparam logic [OFFSET_W-RTC_IDX_W-1:0] RTC_WIN_HI = 9'h01c;

  localparam word_t ID_A500 = 32'h0000_a500;
  localparam word_t ID_1F   = 32'h0000_001f;
  localparam word_t ID_7C   = 32'h0000_007c;
  localparam word_t ID_4    = 32'h0000_0004;

  // Clock RAM byte positions
  localparam logic [RTC_IDX_W-1:0] B_CTRL  = 5'd0;
  localparam logic [RTC_IDX_W-1:0] B_CMD   = 5'd4;
  localparam logic [RTC_IDX_W-1:0] B_HUND  = 5'd5;
  localparam logic [RTC_IDX_W-1:0] B_SEC   = 5'd6;
  localparam logic [RTC_IDX_W-1:0] B_MIN   = 5'd7;
  localparam logic [RTC_IDX_W-1:0] B_HOUR  = 5'd8;
  localparam logic [RTC_IDX_W-1:0] B_DAY   = 5'd9;
  localparam logic [RTC_IDX_W-1:0] B_MONTH = 5'd10;
  localparam logic [RTC_IDX_W-1:0] B_LATCH = 5'h19;

  localparam byte_t BCD_SIXTY     = 8'h60;
  localparam byte_t BCD_HOUR_WRAP = 8'h24;
  localparam byte_t HUND_WRAP_MSK = 8'ha0;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic execute;   // perform the request and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic  carry;
    byte_t value;
  } bcd_inc_t;

  // Increment a BCD byte; carry flags a low-digit rollover
  function automatic bcd_inc_t bcd_inc(input byte_t b);
    bcd_inc_t r;
    byte_t    v;
    v = b + 8'd1;
    r.carry = 1'b0;
    if (v[3:0] == 4'ha) begin
      v = v + 8'h06;
      r.carry = 1'b1;
    end
    r.value = v;
    return r;
  endfunction

endpackage

### src/iorb_ctrl.sv
// Request sequencer: capture, execute and result handshake control.
module iorb_ctrl
  import iorb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t dp_cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready      = 1'b0;
    dp_cmd.capture = 1'b0;
    dp_cmd.execute = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready      = 1'b1;
        dp_cmd.capture = in_tvalid;
      end
      S_EXEC: begin
        dp_cmd.execute = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.execute)  out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.capture |=> state_r == S_EXEC)
    else $error("captured request did not move to execute");

  a_execute_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.execute |=> out_valid_r && state_r == S_IDLE)
    else $error("executed request did not produce a result");

  a_exec_waits_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_valid_r && !out_tready) |=> state_r == S_EXEC)
    else $error("request executed while the result slot was full");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_IDLE && !out_valid_r))
    else $error("reset did not clear the controller");

endmodule

### src/iorb_datapath.sv
// Register file, clock RAM, BCD clock advance and read decode.
module iorb_datapath
  import iorb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t dp_cmd,
  input  cmd_t    in_command,
  input  offset_t in_word_offset,
  input  word_t   in_write_data,
  output word_t   out_read_data,
  output logic    out_mapped
);

  // Request registers
  cmd_t    cmd_r;
  offset_t ofs_r;
  word_t   wdata_r;

  // Architectural state
  byte_t                ram_r [CLOCK_RAM_BYTES];
  byte_t                ram_nxt [CLOCK_RAM_BYTES];
  logic [3:0]           presc_r, presc_nxt;
  word_t                pptr_r, pptr_nxt;
  byte_t                misc_r, misc_nxt;
  word_t                lmask_a_r, lmask_a_nxt;
  word_t                lmask_b_r, lmask_b_nxt;
  word_t                imask_a_r, imask_a_nxt;
  word_t                imask_b_r, imask_b_nxt;

  // Result register
  word_t rdata_r, rdata_nxt;
  logic  mapped_r, mapped_nxt;

  logic                 rtc_hit;
  logic [RTC_IDX_W-1:0] idx;
  logic [3:0]           presc_inc;
  bcd_inc_t             hund_i, sec_i, min_i, hour_i;

  assign rtc_hit   = ofs_r[OFFSET_W-1:RTC_IDX_W] == RTC_WIN_HI;
  assign idx       = ofs_r[RTC_IDX_W-1:0];
  assign presc_inc = presc_r + 4'd1;
  assign hund_i    = bcd_inc(ram_r[B_HUND]);
  assign sec_i     = bcd_inc(ram_r[B_SEC]);
  assign min_i     = bcd_inc(ram_r[B_MIN]);
  assign hour_i    = bcd_inc(ram_r[B_HOUR]);

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r   <= in_command;
      ofs_r   <= in_word_offset;
      wdata_r <= in_write_data;
    end
  end

  // Read decode
  always_comb begin
    rdata_nxt  = '0;
    mapped_nxt = 1'b0;
    if (cmd_r == CMD_READ) begin
      if (rtc_hit) begin
        rdata_nxt  = {24'd0, ram_r[idx]};
        mapped_nxt = 1'b1;
      end else if (ofs_r[OFFSET_W-1:4] == ID_WIN_HI) begin
        unique case (ofs_r[3:0])
          4'h0, 4'h2: begin
            rdata_nxt  = ID_7C;
            mapped_nxt = 1'b1;
          end
          4'h4, 4'h8, 4'hc: begin
            rdata_nxt  = ID_4;
            mapped_nxt = 1'b1;
          end
          4'h1, 4'h3: mapped_nxt = 1'b0;  // left-out pass-through words
          default:    mapped_nxt = 1'b1;
        endcase
      end else begin
        unique case (ofs_r)
          OFS_ID_A500:   begin rdata_nxt = ID_A500;            mapped_nxt = 1'b1; end
          OFS_PAR_PTR:   begin rdata_nxt = pptr_r;             mapped_nxt = 1'b1; end
          OFS_ID_1F:     begin rdata_nxt = ID_1F;              mapped_nxt = 1'b1; end
          OFS_MISC:      begin rdata_nxt = {24'd0, misc_r};    mapped_nxt = 1'b1; end
          OFS_LIO_MASKA: begin rdata_nxt = lmask_a_r;          mapped_nxt = 1'b1; end
          OFS_LIO_MASKB: begin rdata_nxt = lmask_b_r;          mapped_nxt = 1'b1; end
          OFS_INT_MASKA: begin rdata_nxt = imask_a_r;          mapped_nxt = 1'b1; end
          OFS_INT_MASKB: begin rdata_nxt = imask_b_r;          mapped_nxt = 1'b1; end
          default:       mapped_nxt = 1'b0;
        endcase
      end
    end
  end

  // State update for writes and ticks
  always_comb begin
    ram_nxt     = ram_r;
    presc_nxt   = presc_r;
    pptr_nxt    = pptr_r;
    misc_nxt    = misc_r;
    lmask_a_nxt = lmask_a_r;
    lmask_b_nxt = lmask_b_r;
    imask_a_nxt = imask_a_r;
    imask_b_nxt = imask_b_r;
    if (cmd_r == CMD_WRITE) begin
      if (rtc_hit) begin
        ram_nxt[idx] = wdata_r[7:0];
        // Snapshot the time into the latch bytes when the latch command is written
        if (idx == B_CMD && !ram_r[B_CTRL][7] && wdata_r[7]) begin
          ram_nxt[B_LATCH]        = ram_r[B_SEC];
          ram_nxt[B_LATCH + 5'd1] = ram_r[B_MIN];
          ram_nxt[B_LATCH + 5'd2] = ram_r[B_HOUR];
          ram_nxt[B_LATCH + 5'd3] = ram_r[B_DAY];
          ram_nxt[B_LATCH + 5'd4] = ram_r[B_MONTH];
        end
      end else begin
        unique case (ofs_r)
          OFS_PAR_PTR:   pptr_nxt    = wdata_r;
          OFS_MISC:      misc_nxt    = wdata_r[7:0];
          OFS_LIO_MASKA: lmask_a_nxt = wdata_r;
          OFS_LIO_MASKB: lmask_b_nxt = wdata_r;
          OFS_INT_MASKA: imask_a_nxt = wdata_r;
          OFS_INT_MASKB: imask_b_nxt = wdata_r;
          default: ;
        endcase
      end
    end else if (cmd_r == CMD_TICK) begin
      presc_nxt = presc_inc;
      if (presc_inc >= 4'(TICKS_PER_HUNDREDTH)) begin
        presc_nxt       = 4'd0;
        ram_nxt[B_HUND] = hund_i.value;
        if (hund_i.carry && (hund_i.value & HUND_WRAP_MSK) == HUND_WRAP_MSK) begin
          ram_nxt[B_HUND] = 8'd0;
          ram_nxt[B_SEC]  = sec_i.value;
          if (sec_i.carry && sec_i.value == BCD_SIXTY) begin
            ram_nxt[B_SEC] = 8'd0;
            ram_nxt[B_MIN] = min_i.value;
            if (min_i.carry && min_i.value == BCD_SIXTY) begin
              ram_nxt[B_MIN] = 8'd0;
              if (hour_i.value == BCD_HOUR_WRAP) begin
                ram_nxt[B_HOUR] = 8'd0;
                ram_nxt[B_DAY]  = ram_r[B_DAY] + 8'd1;
              end else begin
                ram_nxt[B_HOUR] = hour_i.value;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CLOCK_RAM_BYTES; i++) ram_r[i] <= '0;
      presc_r   <= '0;
      pptr_r    <= '0;
      misc_r    <= '0;
      lmask_a_r <= '0;
      lmask_b_r <= '0;
      imask_a_r <= '0;
      imask_b_r <= '0;
    end else if (dp_cmd.execute) begin
      ram_r     <= ram_nxt;
      presc_r   <= presc_nxt;
      pptr_r    <= pptr_nxt;
      misc_r    <= misc_nxt;
      lmask_a_r <= lmask_a_nxt;
      lmask_b_r <= lmask_b_nxt;
      imask_a_r <= imask_a_nxt;
      imask_b_r <= imask_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      rdata_r  <= rdata_nxt;
      mapped_r <= mapped_nxt;
    end
  end

  assign out_read_data = rdata_r;
  assign out_mapped    = mapped_r;

endmodule

### src/io_register_block_with_bcd_rtc.sv
// Top level of the I/O register block with battery-clock RAM and BCD time of day.
// Flow: a request taken at the in side is captured into the request registers, then
//   executed and loaded into the result register, waiting while a result is unread.
// Sequencing: a new request is taken only once the previous one has executed.
//   A new request is taken while a finished result still waits on the out side.
// Reset: synchronous, active low; clears clock RAM, prescaler, state registers, sequencer
//   at once, no clearing pass; request and result registers are not reset.
module io_register_block_with_bcd_rtc
  import iorb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [13:0] word_offset, [45:14] write_data, [47:46] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_data
  output logic [0:0]  out_tuser   // [0] mapped
);

  dp_cmd_t dp_cmd;
  word_t   read_data;
  logic    mapped;

  // Sequencer: hold a request through execute, stall while the result is unread
  iorb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd)
  );

  // Datapath: registers, clock RAM, tick advance and read decode
  iorb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .in_command     (in_tuser),
    .in_word_offset (in_tdata[OFFSET_W-1:0]),
    .in_write_data  (in_tdata[OFFSET_W+DATA_W-1:OFFSET_W]),
    .out_read_data  (read_data),
    .out_mapped     (mapped)
  );

  assign out_tdata    = read_data;
  assign out_tuser[0] = mapped;

endmodule
